[hw/rtl/rpn_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types, codes, microcode table and helpers of the RPN stack calculator.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int STACK_DEPTH = 4;
  localparam int WORD_W      = 32;
  localparam int UADDR_W     = 5;
  localparam int DIV_STEPS   = 31;
  localparam int DIV_CNT_W   = 5;

  localparam logic [2:0] OP_PUSH = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;
  localparam logic [1:0] ST_DIV0  = 2'd3;

  localparam logic [UADDR_W-1:0] UA_IDLE     = 5'd0;
  localparam logic [UADDR_W-1:0] UA_PUSH     = 5'd1;
  localparam logic [UADDR_W-1:0] UA_POP_B    = 5'd2;
  localparam logic [UADDR_W-1:0] UA_LD_B     = 5'd3;
  localparam logic [UADDR_W-1:0] UA_POP_A    = 5'd4;
  localparam logic [UADDR_W-1:0] UA_LD_A     = 5'd5;
  localparam logic [UADDR_W-1:0] UA_ADD      = 5'd6;
  localparam logic [UADDR_W-1:0] UA_SUB      = 5'd7;
  localparam logic [UADDR_W-1:0] UA_MUL      = 5'd8;
  localparam logic [UADDR_W-1:0] UA_MUL_SAT  = 5'd9;
  localparam logic [UADDR_W-1:0] UA_DIV      = 5'd10;
  localparam logic [UADDR_W-1:0] UA_DIV_GO   = 5'd11;
  localparam logic [UADDR_W-1:0] UA_DIV_WAIT = 5'd12;
  localparam logic [UADDR_W-1:0] UA_DIV_LD   = 5'd13;
  localparam logic [UADDR_W-1:0] UA_PUSH_R   = 5'd14;
  localparam logic [UADDR_W-1:0] UA_RD_TOP   = 5'd15;
  localparam logic [UADDR_W-1:0] UA_EMIT     = 5'd16;
  localparam logic [UADDR_W-1:0] UA_DIV0     = 5'd17;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LATCH,
    DP_PUSH_IN,
    DP_POP,
    DP_LOAD_B,
    DP_LOAD_A,
    DP_ADD,
    DP_SUB,
    DP_MUL,
    DP_MUL_SAT,
    DP_DIV_START,
    DP_DIV_LOAD,
    DP_PUSH_R,
    DP_SET_DIV0,
    DP_READ_TOP,
    DP_EMIT
  } dp_op_t;

  typedef enum logic [2:0] {
    J_NEXT,
    J_GOTO,
    J_DISPATCH,
    J_OPSEL,
    J_IF_BZERO,
    J_IF_DIV_BUSY
  } jump_t;

  typedef struct packed {
    dp_op_t              op;
    jump_t               jmp;
    logic [UADDR_W-1:0]  target;
  } ucode_t;

  typedef struct packed {
    logic b_zero;
    logic div_busy;
  } dp_flags_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_PREP,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

  function automatic ucode_t ucode_rom(input logic [UADDR_W-1:0] addr);
    ucode_t w;
    w = '{op: DP_NOP, jmp: J_GOTO, target: UA_IDLE};
    unique case (addr)
      UA_IDLE:     w = '{op: DP_LATCH,     jmp: J_DISPATCH,    target: UA_IDLE};
      UA_PUSH:     w = '{op: DP_PUSH_IN,   jmp: J_GOTO,        target: UA_RD_TOP};
      UA_POP_B:    w = '{op: DP_POP,       jmp: J_NEXT,        target: UA_IDLE};
      UA_LD_B:     w = '{op: DP_LOAD_B,    jmp: J_NEXT,        target: UA_IDLE};
      UA_POP_A:    w = '{op: DP_POP,       jmp: J_NEXT,        target: UA_IDLE};
      UA_LD_A:     w = '{op: DP_LOAD_A,    jmp: J_OPSEL,       target: UA_IDLE};
      UA_ADD:      w = '{op: DP_ADD,       jmp: J_GOTO,        target: UA_PUSH_R};
      UA_SUB:      w = '{op: DP_SUB,       jmp: J_GOTO,        target: UA_PUSH_R};
      UA_MUL:      w = '{op: DP_MUL,       jmp: J_NEXT,        target: UA_IDLE};
      UA_MUL_SAT:  w = '{op: DP_MUL_SAT,   jmp: J_GOTO,        target: UA_PUSH_R};
      UA_DIV:      w = '{op: DP_NOP,       jmp: J_IF_BZERO,    target: UA_DIV0};
      UA_DIV_GO:   w = '{op: DP_DIV_START, jmp: J_NEXT,        target: UA_IDLE};
      UA_DIV_WAIT: w = '{op: DP_NOP,       jmp: J_IF_DIV_BUSY, target: UA_DIV_WAIT};
      UA_DIV_LD:   w = '{op: DP_DIV_LOAD,  jmp: J_NEXT,        target: UA_IDLE};
      UA_PUSH_R:   w = '{op: DP_PUSH_R,    jmp: J_NEXT,        target: UA_IDLE};
      UA_RD_TOP:   w = '{op: DP_READ_TOP,  jmp: J_NEXT,        target: UA_IDLE};
      UA_EMIT:     w = '{op: DP_EMIT,      jmp: J_GOTO,        target: UA_IDLE};
      UA_DIV0:     w = '{op: DP_SET_DIV0,  jmp: J_GOTO,        target: UA_RD_TOP};
      default:     w = '{op: DP_NOP,       jmp: J_GOTO,        target: UA_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [UADDR_W-1:0] entry_addr(input logic [2:0] op);
    logic [UADDR_W-1:0] a;
    a = UA_RD_TOP;
    unique case (op) inside
      OP_PUSH:                        a = UA_PUSH;
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: a = UA_POP_B;
      default:                        a = UA_RD_TOP;
    endcase
    return a;
  endfunction

  function automatic logic [UADDR_W-1:0] op_addr(input logic [2:0] op);
    logic [UADDR_W-1:0] a;
    a = UA_RD_TOP;
    unique case (op)
      OP_ADD:  a = UA_ADD;
      OP_SUB:  a = UA_SUB;
      OP_MUL:  a = UA_MUL;
      OP_DIV:  a = UA_DIV;
      default: a = UA_RD_TOP;
    endcase
    return a;
  endfunction

  function automatic logic [WORD_W-1:0] sat32(input logic [63:0] v);
    logic fits;
    fits = (&v[63:31]) || !(|v[63:31]);
    if (fits) begin
      return v[31:0];
    end else if (v[63]) begin
      return 32'h8000_0000;
    end else begin
      return 32'h7fff_ffff;
    end
  endfunction

endpackage

[hw/rtl/rpn_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_divider
// Iterative signed Q16.16 divider, one quotient bit per cycle, saturating.
// ----------------------------------------------------------------------------
module rpn_divider (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic               busy,
  output logic signed [31:0] quot
);

  rpn_pkg::div_state_t state, state_next;

  logic [31:0] ua;
  logic [31:0] ub;
  logic        neg;
  logic        ovf;
  logic [31:0] rem;
  logic [30:0] dvd;
  logic [30:0] quo;
  logic [rpn_pkg::DIV_CNT_W-1:0] cnt;

  logic        load_en;
  logic        prep_en;
  logic        run_en;
  logic        done_en;
  logic [32:0] partial;
  logic [32:0] trial;
  logic        take;
  logic [31:0] mag;

  always_comb begin
    state_next = state;
    unique case (state)
      rpn_pkg::DIV_IDLE: if (start) state_next = rpn_pkg::DIV_PREP;
      rpn_pkg::DIV_PREP: state_next = rpn_pkg::DIV_RUN;
      rpn_pkg::DIV_RUN:  if (cnt == '0) state_next = rpn_pkg::DIV_DONE;
      rpn_pkg::DIV_DONE: state_next = rpn_pkg::DIV_IDLE;
      default:           state_next = rpn_pkg::DIV_IDLE;
    endcase
  end

  always_comb begin
    busy    = (state != rpn_pkg::DIV_IDLE);
    load_en = (state == rpn_pkg::DIV_IDLE) && start;
    prep_en = (state == rpn_pkg::DIV_PREP);
    run_en  = (state == rpn_pkg::DIV_RUN);
    done_en = (state == rpn_pkg::DIV_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rpn_pkg::DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign partial = {rem, dvd[30]};
  assign trial   = partial - {1'b0, ub};
  assign take    = (partial >= {1'b0, ub});
  assign mag     = {1'b0, quo};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (prep_en) begin
      cnt <= rpn_pkg::DIV_CNT_W'(rpn_pkg::DIV_STEPS - 1);
    end else if (run_en) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      ua  <= a[31] ? 32'(-a) : a;
      ub  <= b[31] ? 32'(-b) : b;
      neg <= a[31] ^ b[31];
    end
    if (prep_en) begin
      ovf <= {15'd0, ua[31:15]} >= ub;
      rem <= {15'd0, ua[31:15]};
      dvd <= {ua[14:0], 16'd0};
      quo <= '0;
    end
    if (run_en) begin
      rem <= take ? trial[31:0] : partial[31:0];
      quo <= {quo[29:0], take};
      dvd <= {dvd[29:0], 1'b0};
    end
    if (done_en) begin
      if (ovf) begin
        quot <= neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
        quot <= neg ? -$signed(mag) : $signed(mag);
      end
    end
  end

endmodule

[hw/rtl/rpn_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_datapath
// Stack memory, fill count, operand registers, ALU and result register.
// ----------------------------------------------------------------------------
module rpn_datapath #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  rpn_pkg::dp_op_t    op,
  input  logic signed [31:0] value,
  output rpn_pkg::dp_flags_t flags,
  output logic               done,
  output logic [1:0]         status,
  output logic [2:0]         depth,
  output logic signed [31:0] top_value
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [31:0] mem [STACK_DEPTH];
  logic [31:0] rdata;

  logic [CW-1:0]      count;
  logic [CW-1:0]      cnt_dec;
  logic [CW+2:0]      cnt_ext;
  logic               full;
  logic               empty;
  logic               zflag;
  logic [1:0]         stat;
  logic signed [31:0] val;
  logic signed [31:0] a_reg;
  logic signed [31:0] b_reg;
  logic signed [31:0] r_reg;
  logic signed [63:0] prod;
  logic signed [63:0] prod_sh;
  logic signed [32:0] sum;
  logic signed [32:0] diff;
  logic signed [31:0] quot;
  logic               div_busy;

  logic               we;
  logic               re;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr;
  logic [31:0]        wdata;

  assign full    = (count == CW'(STACK_DEPTH));
  assign empty   = (count == '0);
  assign cnt_dec = count - CW'(1);
  assign cnt_ext = (CW+3)'(count);
  assign waddr   = count[AW-1:0];
  assign raddr   = cnt_dec[AW-1:0];
  assign we      = ((op == rpn_pkg::DP_PUSH_IN) || (op == rpn_pkg::DP_PUSH_R)) && !full;
  assign wdata   = (op == rpn_pkg::DP_PUSH_IN) ? val : r_reg;
  assign re      = ((op == rpn_pkg::DP_POP) || (op == rpn_pkg::DP_READ_TOP)) && !empty;

  assign sum     = $signed({a_reg[31], a_reg}) + $signed({b_reg[31], b_reg});
  assign diff    = $signed({a_reg[31], a_reg}) - $signed({b_reg[31], b_reg});
  assign prod_sh = prod >>> 16;

  assign flags.b_zero   = (b_reg == '0);
  assign flags.div_busy = div_busy;

  rpn_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (op == rpn_pkg::DP_DIV_START),
    .a     (a_reg),
    .b     (b_reg),
    .busy  (div_busy),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= (op == rpn_pkg::DP_EMIT);
      case (op)
        rpn_pkg::DP_PUSH_IN,
        rpn_pkg::DP_PUSH_R: if (!full) count <= count + CW'(1);
        rpn_pkg::DP_POP:    if (!empty) count <= cnt_dec;
        default:            count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      rpn_pkg::DP_LATCH: begin
        val  <= value;
        stat <= rpn_pkg::ST_OK;
      end
      rpn_pkg::DP_PUSH_IN: begin
        if (full) stat <= rpn_pkg::ST_FULL;
      end
      rpn_pkg::DP_POP: begin
        zflag <= empty;
        if (empty) stat <= rpn_pkg::ST_UNDER;
      end
      rpn_pkg::DP_LOAD_B:   b_reg <= zflag ? '0 : rdata;
      rpn_pkg::DP_LOAD_A:   a_reg <= zflag ? '0 : rdata;
      rpn_pkg::DP_ADD:      r_reg <= rpn_pkg::sat32({{31{sum[32]}}, sum});
      rpn_pkg::DP_SUB:      r_reg <= rpn_pkg::sat32({{31{diff[32]}}, diff});
      rpn_pkg::DP_MUL:      prod  <= 64'(a_reg) * 64'(b_reg);
      rpn_pkg::DP_MUL_SAT:  r_reg <= rpn_pkg::sat32(prod_sh);
      rpn_pkg::DP_DIV_LOAD: r_reg <= quot;
      rpn_pkg::DP_SET_DIV0: stat  <= rpn_pkg::ST_DIV0;
      rpn_pkg::DP_READ_TOP: zflag <= empty;
      rpn_pkg::DP_EMIT: begin
        status    <= stat;
        depth     <= cnt_ext[2:0];
        top_value <= zflag ? '0 : rdata;
      end
      default: ;
    endcase
  end

endmodule

[hw/rtl/rpn_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_sequencer
// Microprogram counter, opcode latch and jump logic over the control ROM.
// ----------------------------------------------------------------------------
module rpn_sequencer (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [2:0]         opcode,
  input  rpn_pkg::dp_flags_t flags,
  output logic               busy,
  output rpn_pkg::dp_op_t    op
);

  logic [rpn_pkg::UADDR_W-1:0] pc, pc_next;
  logic [2:0]                  op_reg;
  rpn_pkg::ucode_t             word;
  logic                        accept;

  assign word   = rpn_pkg::ucode_rom(pc);
  assign accept = start && (pc == rpn_pkg::UA_IDLE);

  always_comb begin
    pc_next = pc;
    unique case (word.jmp)
      rpn_pkg::J_NEXT:        pc_next = pc + 1'b1;
      rpn_pkg::J_GOTO:        pc_next = word.target;
      rpn_pkg::J_DISPATCH:    pc_next = start ? rpn_pkg::entry_addr(opcode) : pc;
      rpn_pkg::J_OPSEL:       pc_next = rpn_pkg::op_addr(op_reg);
      rpn_pkg::J_IF_BZERO:    pc_next = flags.b_zero ? word.target : pc + 1'b1;
      rpn_pkg::J_IF_DIV_BUSY: pc_next = flags.div_busy ? word.target : pc + 1'b1;
      default:                pc_next = rpn_pkg::UA_IDLE;
    endcase
  end

  always_comb begin
    busy = (pc != rpn_pkg::UA_IDLE);
    op   = ((word.jmp == rpn_pkg::J_DISPATCH) && !start) ? rpn_pkg::DP_NOP : word.op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= rpn_pkg::UA_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_reg <= opcode;
    end
  end

endmodule

[hw/rtl/rpn_stack_calculator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_calculator
// Reverse Polish calculator stack of signed Q16.16 words, microcoded control.
// ----------------------------------------------------------------------------
// Usage:
//   Drive opcode and value with start high; the word is taken at a clock edge
//   where start is high and busy is low. busy stays high until the microcode
//   returns to its idle step.
//   Each word yields one result: done is high for exactly one cycle while
//   status, depth and top_value hold it. The receiver cannot stall; results
//   are never held back.
//   Push, undefined opcodes, add, subtract, multiply and divide by zero run
//   through microcode steps alone from accept to done; divide also waits on
//   the iterative divider, which resolves one quotient bit per cycle over 31
//   steps plus setup and sign fix.
//   A new word may be started in the cycle done is high.
//   Reset clears the stack fill count and returns the microcode to idle.
// ----------------------------------------------------------------------------
module rpn_stack_calculator #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [2:0]         opcode,
  input  logic signed [31:0] value,
  output logic               busy,
  output logic               done,
  output logic [1:0]         status,
  output logic [2:0]         depth,
  output logic signed [31:0] top_value
);

  rpn_pkg::dp_op_t    op;
  rpn_pkg::dp_flags_t flags;

  rpn_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .flags  (flags),
    .busy   (busy),
    .op     (op)
  );

  rpn_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .value     (value),
    .flags     (flags),
    .done      (done),
    .status    (status),
    .depth     (depth),
    .top_value (top_value)
  );

endmodule

[hw/rtl/rpn_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_checker
// Port-level checks of the RPN stack calculator, bound to the top level.
// ----------------------------------------------------------------------------
module rpn_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic [2:0]         depth,
  input logic signed [31:0] top_value
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted word");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a word in flight");

  a_empty_top_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (depth == 3'd0)) |-> (top_value == '0))
    else $error("empty stack reports nonzero top");

endmodule

bind rpn_stack_calculator rpn_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .depth     (depth),
  .top_value (top_value)
);
